// File: src/tmp_pkg.sv
// tmp_pkg: shared types and constants for the trapezoidal motion profile
// phase codes, register indexes and the derived profile bundle
// no dependencies
package tmp_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALIM  = 2'd3;

	localparam logic [2:0] PH_BEFORE = 3'd0;
	localparam logic [2:0] PH_ACCEL  = 3'd1;
	localparam logic [2:0] PH_CRUISE = 3'd2;
	localparam logic [2:0] PH_DECEL  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	typedef struct packed {
		logic [30:0]        accel;
		logic [31:0]        ramp_time;
		logic [31:0]        cruise_time;
		logic [32:0]        cruise_end;
		logic [31:0]        total_time;
		logic [31:0]        peak_vel;
		logic [31:0]        ramp_dist;
		logic [31:0]        travel;
		logic               neg;
		logic signed [31:0] start;
	} prof_t;

endpackage

// File: src/tmp_div.sv
// tmp_div: restoring divider, 64-bit dividend by 32-bit divisor
// one quotient bit per cycle, done is high for a single cycle once the last bit is registered
// depends on nothing
module tmp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, num_q[63]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1) && !go;
			if (go)
				cnt_q <= 7'd64;
			else if (cnt_q != 7'd0)
				cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != 7'd0) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			num_q <= {num_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

// File: src/tmp_derive.sv
// tmp_derive: configuration registers and profile derivation sequencer
// computes ramp, cruise and total times, peak velocity and ramp distance
// depends on tmp_pkg and tmp_div
module tmp_derive
	import tmp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output prof_t                prof,
	output logic                 busy
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_T1    = 4'd4;
	localparam logic [3:0] ST_CRU   = 4'd5;
	localparam logic [3:0] ST_TQ    = 4'd6;
	localparam logic [3:0] ST_SQRT  = 4'd7;
	localparam logic [3:0] ST_PEAK  = 4'd8;
	localparam logic [3:0] ST_RDIST = 4'd9;
	localparam logic [3:0] ST_TOT   = 4'd10;

	logic [3:0]         state_q;
	logic signed [31:0] start_q;
	logic signed [31:0] end_q;
	logic [30:0]        vlim_q;
	logic [30:0]        alim_q;
	prof_t              prof_q;
	logic [63:0]        rd_q;
	logic [63:0]        div_num_q;
	logic [31:0]        div_den_q;
	logic               div_go_q;
	logic               div_done;
	logic [63:0]        div_quo;
	logic [63:0]        sq_x_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        sq_root_q;
	logic [5:0]         sq_cnt_q;

	logic [30:0] v_eff;
	logic [30:0] a_eff;
	logic        neg_c;
	logic [32:0] diff33;
	logic [61:0] vv;
	logic        cruise_c;
	logic [31:0] cruise_diff;
	logic [35:0] sq_sh;
	logic [35:0] sq_trial;
	logic [35:0] sq_sub;
	logic        sq_ge;
	logic [62:0] p_full;
	logic [63:0] r_full;
	logic [33:0] tot;

	function automatic logic [31:0] sat32(input logic [63:0] x);
		return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	assign v_eff       = (vlim_q == '0) ? 31'd1 : vlim_q;
	assign a_eff       = (alim_q == '0) ? 31'd1 : alim_q;
	assign neg_c       = end_q < start_q;
	assign diff33      = neg_c ? ({start_q[31], start_q} - {end_q[31], end_q})
	                           : ({end_q[31], end_q} - {start_q[31], start_q});
	assign vv          = v_eff * v_eff;
	assign cruise_c    = {33'd0, prof_q.travel} > {rd_q, 1'b0};
	assign cruise_diff = prof_q.travel - {rd_q[30:0], 1'b0};
	assign sq_sh       = {sq_rem_q, sq_x_q[63:62]};
	assign sq_trial    = {2'b00, sq_root_q, 2'b01};
	assign sq_ge       = sq_sh >= sq_trial;
	assign sq_sub      = sq_sh - sq_trial;
	assign p_full      = prof_q.accel * prof_q.ramp_time;
	assign r_full      = prof_q.peak_vel * prof_q.ramp_time;
	assign tot         = {1'b0, prof_q.ramp_time, 1'b0} + {2'b00, prof_q.cruise_time};

	tmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= '0;
			end_q     <= '0;
			vlim_q    <= 31'd65536;
			alim_q    <= 31'd65536;
			prof_q    <= prof_t'{accel: 31'd65536, default: '0};
			rd_q      <= '0;
			div_num_q <= '0;
			div_den_q <= '0;
			div_go_q  <= 1'b0;
			sq_x_q    <= '0;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_cnt_q  <= '0;
		end else begin
			div_go_q <= (state_q == ST_PREP) || (state_q == ST_CHK)
			         || (state_q == ST_T1 && div_done);
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							REG_START: start_q <= cfg_data;
							REG_END:   end_q   <= cfg_data;
							REG_VLIM:  vlim_q  <= cfg_data[30:0];
							REG_ALIM:  alim_q  <= cfg_data[30:0];
						endcase
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					prof_q.neg    <= neg_c;
					prof_q.travel <= diff33[31:0];
					prof_q.accel  <= a_eff;
					prof_q.start  <= start_q;
					div_num_q     <= {2'b00, vv};
					div_den_q     <= {a_eff, 1'b0};
					state_q       <= ST_RD;
				end
				ST_RD: begin
					if (div_done) begin
						rd_q    <= div_quo;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					div_den_q <= {1'b0, a_eff};
					if (cruise_c) begin
						prof_q.ramp_dist <= rd_q[31:0];
						prof_q.peak_vel  <= {1'b0, v_eff};
						div_num_q        <= {17'd0, v_eff, 16'd0};
						state_q          <= ST_T1;
					end else begin
						prof_q.cruise_time <= '0;
						div_num_q          <= {prof_q.travel, 32'd0};
						state_q            <= ST_TQ;
					end
				end
				ST_T1: begin
					if (div_done) begin
						prof_q.ramp_time <= sat32(div_quo);
						div_num_q        <= {16'd0, cruise_diff, 16'd0};
						div_den_q        <= {1'b0, v_eff};
						state_q          <= ST_CRU;
					end
				end
				ST_CRU: begin
					if (div_done) begin
						prof_q.cruise_time <= sat32(div_quo);
						state_q            <= ST_TOT;
					end
				end
				ST_TQ: begin
					if (div_done) begin
						sq_x_q    <= div_quo;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						sq_cnt_q  <= 6'd32;
						state_q   <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_cnt_q == 6'd0) begin
						prof_q.ramp_time <= sq_root_q;
						state_q          <= ST_PEAK;
					end else begin
						sq_x_q    <= {sq_x_q[61:0], 2'b00};
						sq_rem_q  <= sq_ge ? sq_sub[33:0] : sq_sh[33:0];
						sq_root_q <= {sq_root_q[30:0], sq_ge};
						sq_cnt_q  <= sq_cnt_q - 6'd1;
					end
				end
				ST_PEAK: begin
					prof_q.peak_vel <= p_full[47:16];
					state_q         <= ST_RDIST;
				end
				ST_RDIST: begin
					prof_q.ramp_dist <= sat32({17'd0, r_full[63:17]});
					state_q          <= ST_TOT;
				end
				ST_TOT: begin
					prof_q.total_time <= (tot[33:32] != 2'b00) ? 32'hFFFF_FFFF : tot[31:0];
					prof_q.cruise_end <= {1'b0, prof_q.ramp_time} + {1'b0, prof_q.cruise_time};
					state_q           <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign prof      = prof_q;

endmodule

// File: src/tmp_pipe.sv
// tmp_pipe: five-stage sample pipeline from time to acceleration, velocity, position
// phase select, products, distance, clamp and saturating position
// depends on tmp_pkg
module tmp_pipe
	import tmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        busy,
	input  prof_t       prof,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] accel_out,
	output logic [31:0] velocity_out,
	output logic [31:0] position_out,
	output logic [2:0]  phase
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic accept;

	logic [2:0]  ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	logic [31:0] ta_s1, ta_s2;
	logic [31:0] x_s1;
	logic [62:0] ma_s2;
	logic [63:0] mp_s2, mpc_s2;
	logic [31:0] vw_s3;
	logic [63:0] mv_s3;
	logic [49:0] psum_s3;
	logic [31:0] dist_s4, vel_s4, acc_s4;
	logic [31:0] acc_s5, vel_s5, pos_s5;

	logic [31:0] tu;
	logic [2:0]  ph_c;
	logic [31:0] dt_c, sd_c;
	logic [31:0] vw_c;
	logic [49:0] psum_c;
	logic signed [51:0] dist_c;
	logic [31:0] dist_cl, vel_c, acc_c;
	logic signed [33:0] pos_c;

	assign en5    = !v_s5 || out_ready;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign in_ready = en1 && !busy;
	assign accept = in_valid && in_ready;

	assign tu   = {1'b0, sample_time[30:0]};
	assign dt_c = tu - prof.ramp_time;
	assign sd_c = dt_c - prof.cruise_time;

	always_comb begin
		if (sample_time[31])
			ph_c = PH_BEFORE;
		else if (tu < prof.ramp_time)
			ph_c = PH_ACCEL;
		else if ({1'b0, tu} < prof.cruise_end)
			ph_c = PH_CRUISE;
		else if (tu < prof.total_time)
			ph_c = PH_DECEL;
		else
			ph_c = PH_DONE;
	end

	assign vw_c   = ma_s2[47:16];
	assign psum_c = {18'd0, prof.ramp_dist} + {2'b00, mp_s2[63:16]}
	              + ((ph_s2 == PH_DECEL) ? {2'b00, mpc_s2[63:16]} : 50'd0);

	always_comb begin
		case (ph_s3)
			PH_ACCEL:  dist_c = $signed({5'd0, mv_s3[63:17]});
			PH_CRUISE: dist_c = $signed({2'b00, psum_s3});
			PH_DECEL:  dist_c = $signed({2'b00, psum_s3}) - $signed({5'd0, mv_s3[63:17]});
			PH_DONE:   dist_c = $signed({20'd0, prof.travel});
			default:   dist_c = '0;
		endcase
		if (dist_c[51])
			dist_cl = '0;
		else if (dist_c > $signed({20'd0, prof.travel}))
			dist_cl = prof.travel;
		else
			dist_cl = dist_c[31:0];
		case (ph_s3)
			PH_ACCEL:  vel_c = vw_s3;
			PH_CRUISE: vel_c = prof.peak_vel;
			PH_DECEL:  vel_c = (prof.peak_vel > vw_s3) ? prof.peak_vel - vw_s3 : 32'd0;
			default:   vel_c = '0;
		endcase
		case (ph_s3)
			PH_ACCEL: acc_c = {1'b0, prof.accel};
			PH_DECEL: acc_c = 32'd0 - {1'b0, prof.accel};
			default:  acc_c = '0;
		endcase
	end

	assign pos_c = prof.neg ? ({{2{prof.start[31]}}, prof.start} - $signed({2'b00, dist_s4}))
	                        : ({{2{prof.start[31]}}, prof.start} + $signed({2'b00, dist_s4}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ph_s1 <= ph_c;
			ta_s1 <= (ph_c == PH_ACCEL) ? tu : sd_c;
			x_s1  <= (ph_c == PH_CRUISE) ? dt_c : sd_c;
		end
		if (en2) begin
			ph_s2  <= ph_s1;
			ta_s2  <= ta_s1;
			ma_s2  <= prof.accel * ta_s1;
			mp_s2  <= prof.peak_vel * x_s1;
			mpc_s2 <= prof.peak_vel * prof.cruise_time;
		end
		if (en3) begin
			ph_s3   <= ph_s2;
			vw_s3   <= vw_c;
			mv_s3   <= vw_c * ta_s2;
			psum_s3 <= psum_c;
		end
		if (en4) begin
			ph_s4   <= ph_s3;
			dist_s4 <= dist_cl;
			vel_s4  <= vel_c;
			acc_s4  <= acc_c;
		end
		if (en5) begin
			ph_s5  <= ph_s4;
			acc_s5 <= prof.neg ? 32'd0 - acc_s4 : acc_s4;
			vel_s5 <= prof.neg ? 32'd0 - vel_s4 : vel_s4;
			if (pos_c[33:31] == 3'b000 || pos_c[33:31] == 3'b111)
				pos_s5 <= pos_c[31:0];
			else if (pos_c[33])
				pos_s5 <= 32'h8000_0000;
			else
				pos_s5 <= 32'h7FFF_FFFF;
		end
	end

	assign out_valid    = v_s5;
	assign accel_out    = acc_s5;
	assign velocity_out = vel_s5;
	assign position_out = pos_s5;
	assign phase        = ph_s5;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item missing from first stage");

	a_before_still: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && ph_s5 == PH_BEFORE) |-> (acc_s5 == 32'd0 && vel_s5 == 32'd0))
		else $error("motion reported before start");

	a_cruise_no_accel: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && (ph_s5 == PH_CRUISE || ph_s5 == PH_DONE)) |-> acc_s5 == 32'd0)
		else $error("acceleration during cruise or after finish");

endmodule

// File: src/trapezoidal_motion_profile_top.sv
// trapezoidal_motion_profile_top: trapezoidal velocity profile generator
// depends on tmp_pkg, tmp_derive, tmp_div, tmp_pipe
//
// Usage:
//   cfg channel writes start, end, velocity limit and acceleration limit
//   (index 0..3). Each write starts a derivation of ramp, cruise and total
//   times; it runs through a shared one-bit-per-cycle divider and, for a
//   triangular profile, an iterative square root. Meanwhile cfg_ready and
//   in_ready stay low.
//   in channel carries one signed Q16.16 time sample per item; the out
//   channel returns acceleration, velocity, position and phase for it.
//   An accepted item moves through the five pipeline stages to out_valid;
//   one item per cycle is sustained while the receiver is ready and no
//   derivation runs. A stalled receiver holds the output stage; earlier
//   stages keep filling bubbles, then in_ready drops. Nothing is lost or
//   repeated. Reset loads the reset configuration and its derived profile
//   at once, so items are taken right after reset.
module trapezoidal_motion_profile_top
	import tmp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          sample_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          accel_out,
	output logic [31:0]          velocity_out,
	output logic [31:0]          position_out,
	output logic [2:0]           phase
);

	prof_t prof;
	logic  busy;

	tmp_derive u_derive (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.prof      (prof),
		.busy      (busy)
	);

	tmp_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.busy         (busy),
		.prof         (prof),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_time  (sample_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accel_out    (accel_out),
		.velocity_out (velocity_out),
		.position_out (position_out),
		.phase        (phase)
	);

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for trapezoidal_motion_profile_top
// holds a profile predictor, a scoreboard class and the channel drivers
// depends on tmp_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top
	import tmp_pkg::*;
;

	typedef struct {
		logic [31:0] acc;
		logic [31:0] vel;
		logic [31:0] pos;
		logic [2:0]  ph;
	} kin_t;

	// profile predictor state
	logic [31:0] p_start, p_end;
	logic [30:0] p_vlim, p_alim;
	longint unsigned pr_t1, pr_c, pr_p, pr_r, pr_tt, pr_d;
	bit pr_neg;
	int errors;

	function automatic longint unsigned sat_u32(longint unsigned v);
		return (v > 64'hFFFFFFFF) ? 64'hFFFFFFFF : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void build_profile();
		longint s, e;
		longint unsigned v, a, d, rd, t1, p;
		s = longint'($signed(p_start));
		e = longint'($signed(p_end));
		v = (p_vlim != 0) ? longint'(p_vlim) : 1;
		a = (p_alim != 0) ? longint'(p_alim) : 1;
		pr_neg = e < s;
		d = pr_neg ? s - e : e - s;
		pr_d = d & 64'hFFFFFFFF;
		rd = (v * v) / (2 * a);
		if (d > 2 * rd) begin
			pr_t1 = sat_u32((v << 16) / a);
			pr_r = rd & 64'hFFFFFFFF;
			pr_p = v;
			pr_c = sat_u32(((d - 2 * rd) << 16) / v);
		end else begin
			t1 = int_sqrt((d << 32) / a);
			p = (a * t1) >> 16;
			pr_t1 = t1 & 64'hFFFFFFFF;
			pr_p = p & 64'hFFFFFFFF;
			pr_r = sat_u32((p * t1) >> 17);
			pr_c = 0;
		end
		pr_tt = sat_u32(2 * pr_t1 + pr_c);
	endfunction

	function automatic kin_t sample_profile(logic [31:0] ts);
		longint t, a, t1, c, p, r, d, acc, vel, trav, pos, sd, w;
		kin_t k;
		t = longint'($signed(ts));
		a = (p_alim != 0) ? longint'(p_alim) : 1;
		t1 = pr_t1; c = pr_c; p = pr_p; r = pr_r; d = pr_d;
		acc = 0; vel = 0; trav = 0;
		if (t < 0) begin
			k.ph = PH_BEFORE;
		end else if (t < t1) begin
			k.ph = PH_ACCEL;
			acc = a;
			vel = (a * t) >>> 16;
			trav = (vel * t) >>> 17;
		end else if (t < t1 + c) begin
			k.ph = PH_CRUISE;
			vel = p;
			trav = r + ((p * (t - t1)) >>> 16);
		end else if (t < longint'(pr_tt)) begin
			sd = t - t1 - c;
			w = (a * sd) >>> 16;
			k.ph = PH_DECEL;
			acc = -a;
			vel = (p > w) ? p - w : 0;
			trav = r + ((p * c) >>> 16) + ((p * sd) >>> 16) - ((w * sd) >>> 17);
		end else begin
			k.ph = PH_DONE;
			trav = d;
		end
		if (trav < 0) trav = 0;
		if (trav > d) trav = d;
		if (pr_neg) begin
			acc = -acc;
			vel = -vel;
			pos = longint'($signed(p_start)) - trav;
		end else begin
			pos = longint'($signed(p_start)) + trav;
		end
		if (pos > 64'sd2147483647) pos = 64'sd2147483647;
		if (pos < -64'sd2147483648) pos = -64'sd2147483648;
		k.acc = acc[31:0];
		k.vel = vel[31:0];
		k.pos = pos[31:0];
		return k;
	endfunction

	class kin_scoreboard;
		kin_t pending[$];

		function void note_sample(logic [31:0] ts);
			pending.push_back(sample_profile(ts));
		endfunction

		function void check_kin(kin_t got);
			kin_t x;
			if (pending.size() == 0) begin
				$error("unexpected output item");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.acc !== x.acc) begin
				$error("accel_out exp %h got %h", x.acc, got.acc);
				errors++;
			end
			if (got.vel !== x.vel) begin
				$error("velocity_out exp %h got %h", x.vel, got.vel);
				errors++;
			end
			if (got.pos !== x.pos) begin
				$error("position_out exp %h got %h", x.pos, got.pos);
				errors++;
			end
			if (got.ph !== x.ph) begin
				$error("phase exp %0d got %0d", x.ph, got.ph);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic [31:0] sample_time;
	logic out_valid, out_ready;
	logic [31:0] accel_out, velocity_out, position_out;
	logic [2:0] phase;

	kin_scoreboard sb;
	int send_idle, recv_idle;
	bit hold_recv;
	longint cycles;

	trapezoidal_motion_profile_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_time(sample_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.accel_out(accel_out), .velocity_out(velocity_out),
		.position_out(position_out), .phase(phase)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("trapezoidal_motion_profile_top verification failed");
				$finish;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_kin('{accel_out, velocity_out, position_out, phase});
			out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_START: p_start = val;
			REG_END:   p_end = val;
			REG_VLIM:  p_vlim = val[30:0];
			REG_ALIM:  p_alim = val[30:0];
		endcase
		build_profile();
		@(posedge clk);
	endtask

	// valid stays up between items unless an idle draw lowers it; drain lowers it
	task automatic send_sample(logic [31:0] ts);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_time <= ts;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(ts);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_time();
		longint tt;
		int k;
		tt = longint'(pr_tt);
		k = $urandom_range(9);
		if (k == 0) return $urandom;
		if (k == 1) return -$urandom_range(1000);
		if (k == 2) return (tt + $urandom_range(3)) > 64'h7FFFFFFF ?
			32'h7FFFFFFF : 32'(tt + $urandom_range(3));
		if (k == 3) return 32'(pr_t1 + $urandom_range(2) - 1);
		if (k == 4) return 32'(pr_t1 + pr_c + $urandom_range(2) - 1);
		if (tt > 64'h7FFFFFFF) tt = 64'h7FFFFFFF;
		return 32'(({$urandom, $urandom} % (tt + 1)));
	endfunction

	task automatic random_config(int m);
		logic [31:0] v;
		v = (m == 0) ? 32'h7FFFFFFF : (m == 1) ? 32'h1 : $urandom_range(32'h8000, 32'h100000);
		write_reg(REG_START, (m == 2) ? 32'h80000000 : (m == 3) ? 32'h7FFFFFFF :
			$urandom_range(0, 32'h01000000) - 32'h00800000);
		write_reg(REG_END, (m == 2) ? 32'h7FFFFFFF : (m == 3) ? 32'h80000000 :
			$urandom_range(0, 32'h01000000) - 32'h00800000);
		write_reg(REG_VLIM, (m == 4) ? 32'h0 : v | ($urandom_range(1) << 31));
		write_reg(REG_ALIM, (m == 5) ? 32'h0 : (m == 1) ? 32'h7FFFFFFF :
			$urandom_range(32'h4000, 32'h200000));
	endtask

	initial begin
		sb = new();
		errors = 0;
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; sample_time = '0;
		hold_recv = 0;
		send_idle = 0; recv_idle = 0;
		p_start = 0; p_end = 0; p_vlim = 31'd65536; p_alim = 31'd65536;
		build_profile();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero travel after reset, then a cruise profile
		send_sample(32'h80000000);
		send_sample(32'h7FFFFFFF);
		send_sample(32'h0);
		send_sample(32'hFFFFFFFF);
		drain();
		write_reg(REG_START, 32'h00010000);
		write_reg(REG_END, 32'h000A0000);
		write_reg(REG_VLIM, 32'h00020000);
		write_reg(REG_ALIM, 32'h00010000);
		send_sample(32'h0);
		send_sample(32'(pr_t1 - 1));
		send_sample(32'(pr_t1));
		send_sample(32'(pr_t1 + pr_c));
		send_sample(32'(pr_tt - 1));
		send_sample(32'(pr_tt));
		send_sample(32'hFFFFFFFF);
		drain();
		// reversed triangle, after writing zero limits on the way
		write_reg(REG_START, 32'h00100000);
		write_reg(REG_END, 32'hFFF00000);
		write_reg(REG_VLIM, 32'h0);
		write_reg(REG_ALIM, 32'h0);
		write_reg(REG_VLIM, 32'h7FFFFFFF);
		write_reg(REG_ALIM, 32'h00080000);
		for (int i = 0; i < 6; i++) send_sample(pick_time());
		drain();

		// long receiver hold while sender keeps offering
		hold_recv = 1;
		fork
			begin
				for (int i = 0; i < 20; i++) send_sample(pick_time());
			end
			begin
				repeat (60) @(posedge clk);
				hold_recv = 0;
			end
		join
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 10 : (ph == 1) ? 85 : 0;
			recv_idle = (ph == 0) ? 85 : (ph == 1) ? 10 : 0;
			for (int blk = 0; blk < 8; blk++) begin
				random_config(blk);
				for (int i = 0; i < 60; i++) begin
					if (i % 20 == 0) send_idle = (ph == 2) ? 0 : send_idle;
					send_sample(pick_time());
				end
				drain();
			end
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && sb.pending.size() == 0)
			$display("trapezoidal_motion_profile_top verification clean");
		else
			$display("trapezoidal_motion_profile_top verification failed");
		$finish;
	end

endmodule
